FILE: rtl/hcbd_pkg.sv
// hcbd_pkg: shared types and constants of the chunked body decoder
// used by hcbd_size_parser and http_chunked_body_decoder; no dependencies
`default_nettype none

package hcbd_pkg;

  // decoder phase
  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_DATA    = 2'd1,
    PH_TERM    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  // size line parser state
  typedef enum logic [2:0] {
    SF_LEAD   = 3'd0,
    SF_DIGITS = 3'd1,
    SF_TRAIL  = 3'd2,
    SF_SEMI   = 3'd3,
    SF_BAD    = 3'd4
  } sflag_t;

  // sticky error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_SIZE  = 3'd1,
    ERR_BAD_TERM  = 3'd2,
    ERR_TOO_LARGE = 3'd3,
    ERR_LINE_LONG = 3'd4,
    ERR_EARLY_EOF = 3'd5
  } err_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE = 2'd1;

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
  localparam logic [15:0] MAX_LINE_RESET = 16'd8192;

  // characters
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_SEMI = 8'h3B;
  localparam logic [7:0] CHR_SP   = 8'h20;
  localparam logic [7:0] CHR_TAB  = 8'h09;

endpackage

`default_nettype wire

FILE: rtl/hcbd_size_parser.sv
// hcbd_size_parser: one byte step of the chunk-size line parser
// depends on hcbd_pkg for the parser state encoding and characters
`default_nettype none

module hcbd_size_parser #(
  parameter int SIZE_BITS = 64
) (
  input  hcbd_pkg::sflag_t       flags,
  input  logic [SIZE_BITS-1:0]   acc,
  input  logic [7:0]             ch,
  input  logic                   prior_cr,
  input  logic                   feed_en,
  output hcbd_pkg::sflag_t       flags_next,
  output logic [SIZE_BITS-1:0]   acc_next
);

  hcbd_pkg::sflag_t flags_ws;
  logic             is_ws;
  logic             is_hex;
  logic [3:0]       digit;

  // a held-back bare CR counts as whitespace
  always_comb begin
    flags_ws = flags;
    if (prior_cr && flags == hcbd_pkg::SF_DIGITS) begin
      flags_ws = hcbd_pkg::SF_TRAIL;
    end
  end

  // character classes
  assign is_ws = (ch == hcbd_pkg::CHR_SP) ||
                 (ch >= hcbd_pkg::CHR_TAB && ch <= hcbd_pkg::CHR_CR);

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      digit = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      digit = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      digit = 4'(ch - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // feed the byte itself
  always_comb begin
    flags_next = flags_ws;
    acc_next   = acc;
    if (feed_en && flags_ws != hcbd_pkg::SF_SEMI && flags_ws != hcbd_pkg::SF_BAD) begin
      if (ch == hcbd_pkg::CHR_SEMI) begin
        flags_next = (flags_ws == hcbd_pkg::SF_LEAD) ? hcbd_pkg::SF_BAD : hcbd_pkg::SF_SEMI;
      end else if (is_ws) begin
        if (flags_ws == hcbd_pkg::SF_DIGITS) begin
          flags_next = hcbd_pkg::SF_TRAIL;
        end
      end else if (!is_hex || flags_ws == hcbd_pkg::SF_TRAIL) begin
        flags_next = hcbd_pkg::SF_BAD;
      end else if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
        // next digit would overflow the size field
        flags_next = hcbd_pkg::SF_BAD;
      end else begin
        acc_next   = {acc[SIZE_BITS-5:0], digit};
        flags_next = hcbd_pkg::SF_DIGITS;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder.sv
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder, one byte per transfer
// depends on hcbd_pkg and hcbd_size_parser
//
// Usage:
//   Input channel (in_valid/in_stall) carries data_byte, start_req and
//   end_of_stream. start_req clears state except term_cr before its byte is used.
//   Output channel (out_valid/out_stall) carries payload, is_data, body_done
//   and error_code. A data byte yields one transfer with is_data set; the
//   byte that completes the body or raises an error yields one; once done or
//   in error every later byte yields one that restates status. Other bytes
//   (size line, CR LF, trailers) yield nothing.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   body length limit (index 0) and the line length limit (index 1);
//   cfg_ready is always high. Write it only while the decoder is idle.
// Timing: one byte accepted per cycle unless stalled; a result is registered and
//   appears on the output in the cycle after its byte is accepted. All work for a
//   byte is done in one pass via the size parser and body limit adder/compare.
// Reset: rst (synchronous) returns to the start of a size line and loads
//   the reset limits. When the output register holds a result and
//   out_stall is high, in_stall is raised and no byte is accepted.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // input byte channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            start_req,
  input  logic                            end_of_stream,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      payload,
  output logic                            is_data,
  output logic                            body_done,
  output logic [2:0]                      error_code,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int SUM_W = (SIZE_BITS > 32 ? SIZE_BITS : 32) + 1;

  // decoder state
  hcbd_pkg::phase_t     phase, phase_next;
  logic [SIZE_BITS-1:0] acc, acc_next;
  hcbd_pkg::sflag_t     sflags, sflags_next;
  logic [31:0]          bytes_left, bytes_left_next;
  logic [31:0]          body_total, body_total_next;
  logic [15:0]          line_len, line_len_next;
  logic                 pending_cr, pending_cr_next;
  logic                 term_cr, term_cr_next;
  logic                 finished, finished_next;
  hcbd_pkg::err_t       err, err_next;
  logic [31:0]          max_body;
  logic [15:0]          line_limit;

  // state after an optional start
  hcbd_pkg::phase_t     c_phase;
  logic [SIZE_BITS-1:0] c_acc;
  hcbd_pkg::sflag_t     c_sflags;
  logic [31:0]          c_bytes_left;
  logic [31:0]          c_body_total;
  logic [15:0]          c_line_len;
  logic                 c_pending_cr;
  logic                 c_finished;
  hcbd_pkg::err_t       c_err;

  logic                 accept;
  logic                 active;
  logic                 lf_close;
  logic                 size_ok;
  logic                 size_zero;
  logic                 limit_over;
  logic                 data_last;
  logic                 term_good;
  logic [15:0]          line_inc;
  logic [SUM_W-1:0]     acc_ext;
  logic [SUM_W-1:0]     body_sum;
  hcbd_pkg::sflag_t     p_flags;
  logic [SIZE_BITS-1:0] p_acc;
  logic                 res_valid;
  logic                 res_data;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // start clears state before the byte is used
  always_comb begin
    if (start_req) begin
      c_phase      = hcbd_pkg::PH_SIZE;
      c_acc        = '0;
      c_sflags     = hcbd_pkg::SF_LEAD;
      c_bytes_left = '0;
      c_body_total = '0;
      c_line_len   = '0;
      c_pending_cr = 1'b0;
      c_finished   = 1'b0;
      c_err        = hcbd_pkg::ERR_NONE;
    end else begin
      c_phase      = phase;
      c_acc        = acc;
      c_sflags     = sflags;
      c_bytes_left = bytes_left;
      c_body_total = body_total;
      c_line_len   = line_len;
      c_pending_cr = pending_cr;
      c_finished   = finished;
      c_err        = err;
    end
  end

  // shared decode
  assign active    = !c_finished && c_err == hcbd_pkg::ERR_NONE && !end_of_stream;
  assign lf_close  = c_pending_cr && data_byte == hcbd_pkg::CHR_LF;
  assign size_ok   = c_sflags == hcbd_pkg::SF_DIGITS || c_sflags == hcbd_pkg::SF_TRAIL ||
                     c_sflags == hcbd_pkg::SF_SEMI;
  assign size_zero = c_acc == '0;
  assign acc_ext   = SUM_W'(c_acc);
  assign body_sum  = acc_ext + SUM_W'(c_body_total);
  assign limit_over = body_sum > SUM_W'(max_body);
  assign data_last = c_bytes_left == 32'd1;
  assign term_good = term_cr && data_byte == hcbd_pkg::CHR_LF;
  assign line_inc  = (c_line_len == 16'hFFFF) ? c_line_len : c_line_len + 16'd1;

  // size line byte step
  hcbd_size_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_size_parser (
    .flags      (c_sflags),
    .acc        (c_acc),
    .ch         (data_byte),
    .prior_cr   (c_pending_cr),
    .feed_en    (data_byte != hcbd_pkg::CHR_CR),
    .flags_next (p_flags),
    .acc_next   (p_acc)
  );

  // phase next state
  always_comb begin
    phase_next = c_phase;
    if (active) begin
      case (c_phase)
        hcbd_pkg::PH_DATA: begin
          if (data_last) phase_next = hcbd_pkg::PH_TERM;
        end
        hcbd_pkg::PH_TERM: begin
          if (c_pending_cr && term_good) phase_next = hcbd_pkg::PH_SIZE;
        end
        hcbd_pkg::PH_SIZE: begin
          if (lf_close && size_ok) begin
            if (size_zero) phase_next = hcbd_pkg::PH_TRAILER;
            else if (!limit_over) phase_next = hcbd_pkg::PH_DATA;
          end
        end
        default: begin
          phase_next = c_phase;
        end
      endcase
    end
  end

  // datapath and result
  always_comb begin
    acc_next        = c_acc;
    sflags_next     = c_sflags;
    bytes_left_next = c_bytes_left;
    body_total_next = c_body_total;
    line_len_next   = c_line_len;
    pending_cr_next = c_pending_cr;
    term_cr_next    = term_cr;
    finished_next   = c_finished;
    err_next        = c_err;
    res_data        = 1'b0;
    if (!c_finished && c_err == hcbd_pkg::ERR_NONE && end_of_stream) begin
      err_next = hcbd_pkg::ERR_EARLY_EOF;
    end else if (active) begin
      case (c_phase)
        hcbd_pkg::PH_DATA: begin
          bytes_left_next = c_bytes_left - 32'd1;
          body_total_next = c_body_total + 32'd1;
          res_data        = 1'b1;
          if (data_last) pending_cr_next = 1'b0;
        end
        hcbd_pkg::PH_TERM: begin
          if (!c_pending_cr) begin
            pending_cr_next = 1'b1;
            term_cr_next    = data_byte == hcbd_pkg::CHR_CR;
          end else begin
            pending_cr_next = 1'b0;
            if (!term_good) begin
              err_next = hcbd_pkg::ERR_BAD_TERM;
            end else begin
              sflags_next   = hcbd_pkg::SF_LEAD;
              line_len_next = '0;
            end
          end
        end
        default: begin
          // size line or trailer line
          if (lf_close) begin
            pending_cr_next = 1'b0;
            line_len_next   = '0;
            if (c_phase == hcbd_pkg::PH_TRAILER) begin
              if (c_line_len == 16'd1) finished_next = 1'b1;
            end else begin
              acc_next    = '0;
              sflags_next = hcbd_pkg::SF_LEAD;
              if (!size_ok) begin
                err_next = hcbd_pkg::ERR_BAD_SIZE;
              end else if (!size_zero) begin
                if (limit_over) err_next = hcbd_pkg::ERR_TOO_LARGE;
                else bytes_left_next = acc_ext[31:0];
              end
            end
          end else begin
            line_len_next   = line_inc;
            pending_cr_next = data_byte == hcbd_pkg::CHR_CR;
            if (c_phase == hcbd_pkg::PH_SIZE) begin
              acc_next    = p_acc;
              sflags_next = p_flags;
            end
            if (line_inc >= line_limit) err_next = hcbd_pkg::ERR_LINE_LONG;
          end
        end
      endcase
    end
    res_valid = res_data || finished_next || err_next != hcbd_pkg::ERR_NONE;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hcbd_pkg::PH_SIZE;
      acc        <= '0;
      sflags     <= hcbd_pkg::SF_LEAD;
      bytes_left <= '0;
      body_total <= '0;
      line_len   <= '0;
      pending_cr <= 1'b0;
      term_cr    <= 1'b0;
      finished   <= 1'b0;
      err        <= hcbd_pkg::ERR_NONE;
    end else if (accept) begin
      phase      <= phase_next;
      acc        <= acc_next;
      sflags     <= sflags_next;
      bytes_left <= bytes_left_next;
      body_total <= body_total_next;
      line_len   <= line_len_next;
      pending_cr <= pending_cr_next;
      term_cr    <= term_cr_next;
      finished   <= finished_next;
      err        <= err_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body   <= hcbd_pkg::MAX_BODY_RESET;
      line_limit <= hcbd_pkg::MAX_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hcbd_pkg::CFG_MAX_BODY: max_body <= cfg_data;
        hcbd_pkg::CFG_MAX_LINE: line_limit <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept && res_valid) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      payload    <= res_data ? data_byte : 8'd0;
      is_data    <= res_data;
      body_done  <= finished_next;
      error_code <= err_next;
    end
  end

  // checks
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_data |-> error_code == hcbd_pkg::ERR_NONE && !body_done)
    else $error("data transfer carries status");

  a_data_owed: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DATA |-> bytes_left != 32'd0)
    else $error("data phase with no bytes owed");

  a_done_no_err: assert property (@(posedge clk) disable iff (rst)
    finished |-> err == hcbd_pkg::ERR_NONE)
    else $error("body done together with an error");

  a_sticky_result: assert property (@(posedge clk) disable iff (rst)
    accept && !start_req && (finished || err != hcbd_pkg::ERR_NONE) |=> out_valid)
    else $error("no status transfer after done or error");

endmodule

`default_nettype wire
